// ===== sv/midpoint_line_rasterizer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint line rasterizer
// Clocked property checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge while out of reset.
`define MLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define MLR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLR_ASSERT(label, prop, msg)
`define MLR_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/mlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types and constants of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

    // Request kind, carried on the input tuser bit.
    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_kind_t;

    localparam int COLOR_BITS  = 24;
    localparam int FIELD_BITS  = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    // Status of the command queue, seen by both the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Width of one decoded command: kind, swap and two direction flags,
    // three coordinates, three decision quantities and the color.
    function automatic int cmd_width(input int coord_bits);
        cmd_width = 4 + 3 * coord_bits + 3 * (coord_bits + 2) + COLOR_BITS;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mlr_queue.sv =====
// ----------------------------------------------------------------------------
// mlr_queue
// Two-entry command queue between the decode front and the stepping back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_line_rasterizer_unit_assert.svh"

module mlr_queue #(
    parameter int WIDTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rdata,
    output mlr_pkg::qstat_t      stat
);

    localparam logic [mlr_pkg::QCNT_BITS-1:0] CNT_FULL =
        mlr_pkg::QCNT_BITS'(mlr_pkg::QUEUE_DEPTH);

    logic [WIDTH-1:0]               mem_reg [mlr_pkg::QUEUE_DEPTH];
    logic [mlr_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [mlr_pkg::QPTR_BITS-1:0]  wr_ptr_next;
    logic [mlr_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [mlr_pkg::QPTR_BITS-1:0]  rd_ptr_next;
    logic [mlr_pkg::QCNT_BITS-1:0]  count_reg;
    logic [mlr_pkg::QCNT_BITS-1:0]  count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == mlr_pkg::QCNT_BITS'(mlr_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    `MLR_ASSERT(a_no_push_when_full, stat.full |-> !push, "queue written while full")
    `MLR_ASSERT(a_no_pop_when_empty, stat.empty |-> !pop, "queue read while empty")
    `MLR_ASSERT(a_count_bound, count_reg <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

// ===== sv/mlr_front.sv =====
// ----------------------------------------------------------------------------
// mlr_front
// Accepts requests and decodes a start request into the line setup.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [71:0]                                   s_tdata,
    input  logic                                          s_tuser,
    input  mlr_pkg::qstat_t                               qstat,
    output logic                                          push,
    output logic [mlr_pkg::cmd_width(COORD_BITS)-1:0]     cmd_word
);

    typedef struct packed {
        mlr_pkg::cmd_kind_t              kind;
        logic                            swapped;
        logic                            major_neg;
        logic                            minor_neg;
        logic [COORD_BITS-1:0]           major_pos;
        logic [COORD_BITS-1:0]           minor_pos;
        logic [COORD_BITS-1:0]           major_end;
        logic signed [COORD_BITS+1:0]    inc_straight;
        logic signed [COORD_BITS+1:0]    inc_diagonal;
        logic signed [COORD_BITS+1:0]    decision;
        logic [mlr_pkg::COLOR_BITS-1:0]  color;
    } cmd_t;

    cmd_t                   cmd;
    logic [COORD_BITS-1:0]  sx;
    logic [COORD_BITS-1:0]  sy;
    logic [COORD_BITS-1:0]  ex;
    logic [COORD_BITS-1:0]  ey;
    logic [COORD_BITS-1:0]  adx;
    logic [COORD_BITS-1:0]  ady;
    logic [COORD_BITS-1:0]  maj_d;
    logic [COORD_BITS-1:0]  min_d;

    // Coordinates are taken in their low COORD_BITS bits.
    assign sx = COORD_BITS'(s_tdata[11:0]);
    assign sy = COORD_BITS'(s_tdata[23:12]);
    assign ex = COORD_BITS'(s_tdata[35:24]);
    assign ey = COORD_BITS'(s_tdata[47:36]);

    assign adx = (ex >= sx) ? ex - sx : sx - ex;
    assign ady = (ey >= sy) ? ey - sy : sy - ey;

    always_comb
    begin
        cmd.kind    = mlr_pkg::cmd_kind_t'(s_tuser);
        cmd.swapped = (ady > adx);
        if (cmd.swapped)
        begin
            cmd.major_pos = sy;
            cmd.minor_pos = sx;
            cmd.major_end = ey;
            cmd.major_neg = (ey < sy);
            cmd.minor_neg = (ex < sx);
            maj_d         = ady;
            min_d         = adx;
        end
        else
        begin
            cmd.major_pos = sx;
            cmd.minor_pos = sy;
            cmd.major_end = ex;
            cmd.major_neg = (ex < sx);
            cmd.minor_neg = (ey < sy);
            maj_d         = adx;
            min_d         = ady;
        end
        // Standard midpoint terms: 2m, 2(m - M) and 2m - M.
        cmd.inc_straight = $signed({1'b0, min_d, 1'b0});
        cmd.inc_diagonal = $signed({1'b0, min_d, 1'b0}) - $signed({1'b0, maj_d, 1'b0});
        cmd.decision     = $signed({1'b0, min_d, 1'b0}) - $signed({2'b00, maj_d});
        cmd.color        = s_tdata[71:48];
    end

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;
    assign cmd_word = cmd;

endmodule

`default_nettype wire

// ===== sv/mlr_back.sv =====
// ----------------------------------------------------------------------------
// mlr_back
// Holds the line state, loads a line on a start command, steps one pixel per advance and registers results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midpoint_line_rasterizer_unit_assert.svh"

module mlr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  mlr_pkg::qstat_t                               qstat,
    input  logic [mlr_pkg::cmd_width(COORD_BITS)-1:0]     cmd_word,
    output logic                                          pop,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [47:0]                                   m_tdata,
    output logic                                          m_tuser,
    output logic                                          m_tlast
);

    typedef struct packed {
        mlr_pkg::cmd_kind_t              kind;
        logic                            swapped;
        logic                            major_neg;
        logic                            minor_neg;
        logic [COORD_BITS-1:0]           major_pos;
        logic [COORD_BITS-1:0]           minor_pos;
        logic [COORD_BITS-1:0]           major_end;
        logic signed [COORD_BITS+1:0]    inc_straight;
        logic signed [COORD_BITS+1:0]    inc_diagonal;
        logic signed [COORD_BITS+1:0]    decision;
        logic [mlr_pkg::COLOR_BITS-1:0]  color;
    } cmd_t;

    cmd_t                            cmd;

    logic [COORD_BITS-1:0]           major_pos_reg,  major_pos_next;
    logic [COORD_BITS-1:0]           minor_pos_reg,  minor_pos_next;
    logic [COORD_BITS-1:0]           major_end_reg,  major_end_next;
    logic signed [COORD_BITS+1:0]    decision_reg,   decision_next;
    logic signed [COORD_BITS+1:0]    inc_str_reg,    inc_str_next;
    logic signed [COORD_BITS+1:0]    inc_diag_reg,   inc_diag_next;
    logic                            major_neg_reg,  major_neg_next;
    logic                            minor_neg_reg,  minor_neg_next;
    logic                            swapped_reg,    swapped_next;
    logic                            active_reg,     active_next;
    logic [mlr_pkg::COLOR_BITS-1:0]  color_reg,      color_next;

    logic                            out_valid_reg,  out_valid_next;
    logic [47:0]                     out_data_reg,   out_data_next;
    logic                            out_user_reg,   out_user_next;
    logic                            out_last_reg,   out_last_next;

    logic [COORD_BITS-1:0]           maj_step;
    logic [COORD_BITS-1:0]           min_step;
    logic                            go_diag;
    logic                            res_valid;
    logic                            res_last;
    logic [COORD_BITS-1:0]           res_x;
    logic [COORD_BITS-1:0]           res_y;
    logic [mlr_pkg::COLOR_BITS-1:0]  res_color;

    assign cmd = cmd_t'(cmd_word);

    // A command leaves the queue whenever the output slot is free or drains now.
    assign pop = !qstat.empty && (!out_valid_reg || m_tready);

    assign maj_step = major_neg_reg ? major_pos_reg - 1'b1 : major_pos_reg + 1'b1;
    assign min_step = minor_neg_reg ? minor_pos_reg - 1'b1 : minor_pos_reg + 1'b1;
    assign go_diag  = !decision_reg[COORD_BITS+1] && (decision_reg != '0);

    always_comb
    begin
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        major_end_next = major_end_reg;
        decision_next  = decision_reg;
        inc_str_next   = inc_str_reg;
        inc_diag_next  = inc_diag_reg;
        major_neg_next = major_neg_reg;
        minor_neg_next = minor_neg_reg;
        swapped_next   = swapped_reg;
        active_next    = active_reg;
        color_next     = color_reg;
        res_valid      = 1'b0;
        res_last       = 1'b0;
        res_x          = '0;
        res_y          = '0;
        res_color      = '0;
        if (pop)
        begin
            case (cmd.kind)
                mlr_pkg::CMD_START:
                begin
                    major_pos_next = cmd.major_pos;
                    minor_pos_next = cmd.minor_pos;
                    major_end_next = cmd.major_end;
                    decision_next  = cmd.decision;
                    inc_str_next   = cmd.inc_straight;
                    inc_diag_next  = cmd.inc_diagonal;
                    major_neg_next = cmd.major_neg;
                    minor_neg_next = cmd.minor_neg;
                    swapped_next   = cmd.swapped;
                    color_next     = cmd.color;
                    res_last       = (cmd.major_pos == cmd.major_end);
                    active_next    = !res_last;
                    res_valid      = 1'b1;
                    res_x          = cmd.swapped ? cmd.minor_pos : cmd.major_pos;
                    res_y          = cmd.swapped ? cmd.major_pos : cmd.minor_pos;
                    res_color      = cmd.color;
                end
                mlr_pkg::CMD_ADVANCE:
                begin
                    if (active_reg)
                    begin
                        major_pos_next = maj_step;
                        if (go_diag)
                        begin
                            minor_pos_next = min_step;
                            decision_next  = decision_reg + inc_diag_reg;
                        end
                        else
                        begin
                            decision_next  = decision_reg + inc_str_reg;
                        end
                        res_last    = (maj_step == major_end_reg);
                        active_next = !res_last;
                        res_valid   = 1'b1;
                        res_x       = swapped_reg ? minor_pos_next : maj_step;
                        res_y       = swapped_reg ? maj_step : minor_pos_next;
                        res_color   = color_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {res_color, mlr_pkg::FIELD_BITS'(res_y),
                              mlr_pkg::FIELD_BITS'(res_x)};
            out_user_next  = res_valid;
            out_last_next  = res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_pos_reg <= '0;
            minor_pos_reg <= '0;
            major_end_reg <= '0;
            decision_reg  <= '0;
            inc_str_reg   <= '0;
            inc_diag_reg  <= '0;
            major_neg_reg <= 1'b0;
            minor_neg_reg <= 1'b0;
            swapped_reg   <= 1'b0;
            active_reg    <= 1'b0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            major_end_reg <= major_end_next;
            decision_reg  <= decision_next;
            inc_str_reg   <= inc_str_next;
            inc_diag_reg  <= inc_diag_next;
            major_neg_reg <= major_neg_next;
            minor_neg_reg <= minor_neg_next;
            swapped_reg   <= swapped_next;
            active_reg    <= active_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    `MLR_ASSERT(a_last_ends_line, (pop && res_last) |=> !active_reg, "line still active after its last pixel")
    `MLR_ASSERT(a_idle_result_zero, (out_valid_reg && !out_user_reg) |-> (out_data_reg == '0 && !out_last_reg), "idle result not cleared")
    `MLR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid_reg && !active_reg), "not idle in reset")

endmodule

`default_nettype wire

// ===== sv/midpoint_line_rasterizer_unit.sv =====
// Path: a request accepted by the front is written into the command queue; the
//   back pops it from there and registers its result in the output register.
// Throughput: one request per cycle while the queue is not full, one pixel per
//   clock while m_tready is high, set by the stepper's single compare-and-add.
// Reset: asynchronous, active low; clears the queue, ends any line and empties
//   the output register.
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit
// Midpoint line stepper with a decode front, a command queue and a stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata fields from bit 0: start_x[11:0], start_y[23:12], end_x[35:24],
    // end_y[47:36], color[71:48].
    input  logic [71:0]  s_tdata,
    // s_tuser fields from bit 0: action (0 starts a line, 1 advances a pixel).
    input  logic         s_tuser,
    // Pixel channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata fields from bit 0: pixel_x[11:0], pixel_y[23:12],
    // pixel_color[47:24].
    output logic [47:0]  m_tdata,
    // m_tuser fields from bit 0: valid_res (1 when a pixel is given).
    output logic         m_tuser,
    // m_tlast: the pixel is the line's endpoint.
    output logic         m_tlast
);

    // Every request, start or advance, yields exactly one result. The front
    // decodes a start request into the major axis, the step directions and
    // the decision increments in the cycle it is accepted, and writes the
    // decoded command into a two-entry queue. The back pops a command when its
    // output register is free or being drained, and either loads a new line or,
    // with a line in progress, takes one midpoint step. The queue lets the input
    // keep flowing while a result waits on the output, and its full flag alone
    // sets s_tready, so no path runs from m_tready to s_tready.

    localparam int CMD_W = mlr_pkg::cmd_width(COORD_BITS);

    logic             push;
    logic             pop;
    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] queue_cmd;
    mlr_pkg::qstat_t  qstat;

    mlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .qstat    (qstat),
        .push     (push),
        .cmd_word (front_cmd)
    );

    mlr_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .pop   (pop),
        .rdata (queue_cmd),
        .stat  (qstat)
    );

    // The back keeps the line state; an advance with no line in progress
    // gives a result with m_tuser low and all data zero.
    mlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .cmd_word (queue_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
